// ===== design/quintic_curve_heading_curvature_assert.svh =====
// Assertion macros for the quintic curve block.
`ifndef QUINTIC_CURVE_HEADING_CURVATURE_ASSERT_SVH
`define QUINTIC_CURVE_HEADING_CURVATURE_ASSERT_SVH

// Same-cycle implication.
`define QCHC_AST_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define QCHC_AST_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/qchc_pkg.sv =====
package qchc_pkg;

  localparam int X_FRAC_BITS      = 16;
  localparam int COEF_FRAC_BITS   = 48;
  localparam int CORDIC_STEPS_DEF = 20;

  localparam int NCOEF     = 6;
  localparam int CFG_IDX_W = $clog2(NCOEF);
  localparam int COEF_W    = 64;
  localparam int X_W       = 32;
  localparam int OUT_W     = 32;
  localparam int HEAD_W    = 18;

  // polynomial lanes
  localparam int ACC_W      = 256;
  localparam int LIMBS      = ACC_W / 32;
  localparam int NLANES     = 3;
  localparam int LANE_Y     = 0;
  localparam int LANE_S     = 1;
  localparam int LANE_P     = 2;
  localparam int POLY_STEPS = 5;
  localparam int PCELL_LAT  = 3;

  localparam int S_MULT [4+1] = '{5, 4, 3, 2, 1};
  localparam int P_MULT [4]   = '{20, 12, 6, 2};

  // heading
  localparam int    CX_W        = 50;
  localparam int    Z_W         = 34;
  localparam int    CORDIC_FRAC = 30;
  localparam int    HROUND      = CORDIC_FRAC - X_FRAC_BITS;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint HMAX = (HALF_PI_Q30 + (64'd1 << (HROUND - 1))) >> HROUND;

  localparam int ATAN_Q30 [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0
  };

  // curvature
  localparam int U_W        = 64;
  localparam int SQRT_STEPS = 32;
  localparam int NUM_W      = X_W + 3 * X_FRAC_BITS;
  localparam int DEN_W      = U_W + 32;
  localparam int Q_W        = 33;
  localparam int CURV_LAT   = 1 + SQRT_STEPS + 2 + Q_W + 2;

  typedef logic [NCOEF-1:0][COEF_W-1:0] coef_set_t;
  typedef logic [NLANES-1:0][ACC_W-1:0] lanes_t;

  typedef struct packed {
    logic [U_W-1:0]   u;
    logic [OUT_W-1:0] mag;
    logic             neg;
  } kside_t;

  // Horner term for a lane at step j, already scaled to the accumulator grid.
  function automatic logic [ACC_W-1:0] poly_term(input int lane, input int j,
                                                  input coef_set_t c);
    logic [ACC_W-1:0] v;
    logic [CFG_IDX_W-1:0] idx;
    int m;
    int sh;
    idx = '0;
    m   = 0;
    sh  = 0;
    unique case (lane)
      LANE_Y: begin
        if (j <= POLY_STEPS) begin
          idx = CFG_IDX_W'(POLY_STEPS - j);
          m   = 1;
          sh  = X_FRAC_BITS * j;
        end
      end
      LANE_S: begin
        if (j >= 1) begin
          idx = CFG_IDX_W'(POLY_STEPS + 1 - j);
          m   = S_MULT[j-1];
          sh  = X_FRAC_BITS * (j - 1);
        end
      end
      LANE_P: begin
        if (j >= 2) begin
          idx = CFG_IDX_W'(POLY_STEPS + 2 - j);
          m   = P_MULT[j-2];
          sh  = X_FRAC_BITS * (j - 2);
        end
      end
      default: m = 0;
    endcase
    v = {{(ACC_W-COEF_W){c[idx][COEF_W-1]}}, c[idx]};
    return (v * ACC_W'(m)) << sh;
  endfunction

  function automatic int rnd_shift(input int lane);
    return COEF_FRAC_BITS + (POLY_STEPS - 1 - lane) * X_FRAC_BITS;
  endfunction

  // arithmetic shift, then clamp to signed 32 bits
  function automatic logic [OUT_W-1:0] sat_shift(input logic [ACC_W-1:0] v, input int s);
    logic [ACC_W-1:0] t;
    t = ACC_W'($signed(v) >>> s);
    if ((&t[ACC_W-1:OUT_W-1]) || !(|t[ACC_W-1:OUT_W-1])) begin
      return t[OUT_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

endpackage

// ===== design/qchc_pcell.sv =====
module qchc_pcell #(
  parameter int J = 1
) (
  input  logic                clk,
  input  logic                en,
  input  qchc_pkg::coef_set_t coefs,
  input  logic [31:0]         x_in,
  input  qchc_pkg::lanes_t    acc_in,
  output logic [31:0]         x_out,
  output qchc_pkg::lanes_t    acc_out
);

  localparam int NL = qchc_pkg::NLANES;
  localparam int AW = qchc_pkg::ACC_W;
  localparam int LB = qchc_pkg::LIMBS;

  typedef logic [LB-1:0][63:0] pp_t;

  pp_t              pp [NL];
  qchc_pkg::lanes_t acc_a;
  qchc_pkg::lanes_t sum_b;
  qchc_pkg::lanes_t dif_b;
  qchc_pkg::lanes_t ev;
  qchc_pkg::lanes_t od;
  logic [AW+31:0]   odw [NL];
  logic [31:0]      x_a;
  logic [31:0]      x_b;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      ev[l]  = '0;
      odw[l] = '0;
      for (int k = 0; k < LB / 2; k++) begin
        ev[l][64*k +: 64]       = pp[l][2*k];
        odw[l][64*k + 32 +: 64] = pp[l][2*k+1];
      end
      od[l] = odw[l][AW-1:0];
    end
  end

  // stage A: limb products with x as unsigned; stage B: sum and sign fix; stage C: add
  always_ff @(posedge clk) begin
    if (en) begin
      x_a   <= x_in;
      x_b   <= x_a;
      x_out <= x_b;
      acc_a <= acc_in;
      for (int l = 0; l < NL; l++) begin
        for (int i = 0; i < LB; i++) begin
          pp[l][i] <= 64'(acc_in[l][32*i +: 32]) * 64'(x_in);
        end
        sum_b[l]   <= ev[l] + od[l];
        dif_b[l]   <= qchc_pkg::poly_term(l, J, coefs)
                      - (x_a[31] ? (acc_a[l] << 32) : AW'(0));
        acc_out[l] <= sum_b[l] + dif_b[l];
      end
    end
  end

endmodule

// ===== design/qchc_ccell.sv =====
module qchc_ccell #(
  parameter int I = 0
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [qchc_pkg::CX_W-1:0]     cx_in,
  input  logic signed [qchc_pkg::CX_W-1:0]     cy_in,
  input  logic signed [qchc_pkg::Z_W-1:0]      z_in,
  output logic signed [qchc_pkg::CX_W-1:0]     cx_out,
  output logic signed [qchc_pkg::CX_W-1:0]     cy_out,
  output logic signed [qchc_pkg::Z_W-1:0]      z_out
);

  localparam logic signed [qchc_pkg::Z_W-1:0] ANG = qchc_pkg::Z_W'(qchc_pkg::ATAN_Q30[I]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!cy_in[qchc_pkg::CX_W-1]) begin
        cx_out <= cx_in + (cy_in >>> I);
        cy_out <= cy_in - (cx_in >>> I);
        z_out  <= z_in + ANG;
      end else begin
        cx_out <= cx_in - (cy_in >>> I);
        cy_out <= cy_in + (cx_in >>> I);
        z_out  <= z_in - ANG;
      end
    end
  end

endmodule

// ===== design/qchc_scell.sv =====
module qchc_scell #(
  parameter int K = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qchc_pkg::U_W-1:0]  v_in,
  input  logic [qchc_pkg::U_W-1:0]  r_in,
  input  qchc_pkg::kside_t          side_in,
  output logic [qchc_pkg::U_W-1:0]  v_out,
  output logic [qchc_pkg::U_W-1:0]  r_out,
  output qchc_pkg::kside_t          side_out
);

  localparam logic [qchc_pkg::U_W-1:0] BITV = qchc_pkg::U_W'(1) << (62 - 2 * K);

  logic [qchc_pkg::U_W-1:0] trial;

  assign trial = r_in + BITV;

  // one result bit of the square root per cell
  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (v_in >= trial) begin
        v_out <= v_in - trial;
        r_out <= (r_in >> 1) + BITV;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

// ===== design/qchc_dcell.sv =====
module qchc_dcell #(
  parameter int B = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qchc_pkg::NUM_W-1:0]  rem_in,
  input  logic [qchc_pkg::DEN_W-1:0]  den_in,
  input  logic [qchc_pkg::Q_W-1:0]    q_in,
  input  logic                        neg_in,
  output logic [qchc_pkg::NUM_W-1:0]  rem_out,
  output logic [qchc_pkg::DEN_W-1:0]  den_out,
  output logic [qchc_pkg::Q_W-1:0]    q_out,
  output logic                        neg_out
);

  localparam int T_W = qchc_pkg::DEN_W + qchc_pkg::Q_W - 1;

  logic [T_W-1:0] t;
  logic           fits;

  assign t    = T_W'(den_in) << B;
  assign fits = t <= T_W'(rem_in);

  // one quotient bit per cell, restoring
  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      neg_out <= neg_in;
      rem_out <= fits ? rem_in - t[qchc_pkg::NUM_W-1:0] : rem_in;
      q_out   <= fits ? q_in | (qchc_pkg::Q_W'(1) << B) : q_in;
    end
  end

endmodule

// ===== design/quintic_curve_heading_curvature.sv =====
// Quintic curve evaluator: offset, slope, second derivative, heading, curvature.
// Config: write coef_c0..coef_c5 (index 0..5, Q16.48) on cfg_valid/cfg_data while
//   the block is idle; cfg_ready is always high, indexes above five are dropped.
// Input: one x (Q16.16) per s_tvalid/s_tready transaction.
// Output: one result per input in order on m_tvalid/m_tready.
// Throughput: one item per cycle while s_tready is high, fully pipelined.
// Pipeline depth is set by the chains of cells: five Horner cells of three
//   stages, a 32-cell square root and a 33-cell long division behind the slope
//   and second derivative.
// Stall: the output register plus a skid register absorb a receiver stall;
//   the pipeline freezes and s_tready drops only once the skid is full.
// Reset: rst clears the coefficients, all stage valid bits and the valid bits
//   of both output registers; no clearing pass is needed.
`include "quintic_curve_heading_curvature_assert.svh"

module quintic_curve_heading_curvature #(
  parameter int CORDIC_STEPS = qchc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qchc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qchc_pkg::COEF_W-1:0]       cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // x_coord
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // x_echo, offset_y, slope, second_deriv, heading, curvature, zero pad
  output logic [183:0]                      m_tdata
);

  localparam int NL     = qchc_pkg::NLANES;
  localparam int AW     = qchc_pkg::ACC_W;
  localparam int OW     = qchc_pkg::OUT_W;
  localparam int HW     = qchc_pkg::HEAD_W;
  localparam int STAGES = 1 + qchc_pkg::POLY_STEPS * qchc_pkg::PCELL_LAT + 2
                          + qchc_pkg::CURV_LAT;
  localparam int HD     = qchc_pkg::CURV_LAT - 1 - CORDIC_STEPS;
  localparam int QR_W   = qchc_pkg::Q_W + 1;
  localparam int RES_W  = 5 * OW + HW;
  localparam int PAD_W  = 184 - RES_W;

  typedef struct packed {
    logic [OW-1:0] p;
    logic [OW-1:0] s;
    logic [OW-1:0] y;
    logic [OW-1:0] x;
  } side_t;

  typedef struct packed {
    logic [OW-1:0] curvature;
    logic [HW-1:0] heading;
    logic [OW-1:0] second_deriv;
    logic [OW-1:0] slope;
    logic [OW-1:0] offset_y;
    logic [OW-1:0] x_echo;
  } result_t;

  qchc_pkg::coef_set_t coefs;
  logic [STAGES-1:0]   vld;
  logic                en;
  logic                pipe_vld;
  logic                out_valid;
  logic                skid_valid;
  result_t             res_in;
  result_t             res_q;
  result_t             skid_q;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (cfg_valid && cfg_ready
                 && (cfg_index < qchc_pkg::CFG_IDX_W'(qchc_pkg::NCOEF))) begin
      coefs[cfg_index] <= cfg_data;
    end
  end

  // flow control
  assign en       = !skid_valid;
  assign s_tready = en;
  assign pipe_vld = vld[STAGES-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], s_tvalid};
    end
  end

  // input stage
  logic [31:0] x0;

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= s_tdata;
    end
  end

  // Horner chain
  logic [31:0]      px   [qchc_pkg::POLY_STEPS+1];
  qchc_pkg::lanes_t pacc [qchc_pkg::POLY_STEPS+1];

  assign px[0] = x0;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      pacc[0][l] = qchc_pkg::poly_term(l, 0, coefs);
    end
  end

  for (genvar j = 0; j < qchc_pkg::POLY_STEPS; j++) begin : g_poly
    qchc_pcell #(.J(j + 1)) u_pcell (
      .clk     (clk),
      .en      (en),
      .coefs   (coefs),
      .x_in    (px[j]),
      .acc_in  (pacc[j]),
      .x_out   (px[j+1]),
      .acc_out (pacc[j+1])
    );
  end

  // rounding and saturation
  qchc_pkg::lanes_t r1;
  logic [OW-1:0]    r2 [NL];
  logic [31:0]      x_r1;
  logic [31:0]      x_r2;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r1 <= px[qchc_pkg::POLY_STEPS];
      x_r2 <= x_r1;
      for (int l = 0; l < NL; l++) begin
        r1[l] <= pacc[qchc_pkg::POLY_STEPS][l]
                 + (AW'(1) << (qchc_pkg::rnd_shift(l) - 1));
        r2[l] <= qchc_pkg::sat_shift(r1[l], qchc_pkg::rnd_shift(l));
      end
    end
  end

  // heading
  logic signed [qchc_pkg::CX_W-1:0] ccx [CORDIC_STEPS+1];
  logic signed [qchc_pkg::CX_W-1:0] ccy [CORDIC_STEPS+1];
  logic signed [qchc_pkg::Z_W-1:0]  cz  [CORDIC_STEPS+1];
  logic signed [qchc_pkg::Z_W-1:0]  hsum;
  logic [HW-1:0]                    head_q;

  assign ccx[0] = qchc_pkg::CX_W'(1) <<< qchc_pkg::CORDIC_FRAC;
  assign ccy[0] = qchc_pkg::CX_W'($signed(r2[qchc_pkg::LANE_S])) <<< qchc_pkg::HROUND;
  assign cz[0]  = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qchc_ccell #(.I(i)) u_ccell (
      .clk    (clk),
      .en     (en),
      .cx_in  (ccx[i]),
      .cy_in  (ccy[i]),
      .z_in   (cz[i]),
      .cx_out (ccx[i+1]),
      .cy_out (ccy[i+1]),
      .z_out  (cz[i+1])
    );
  end

  assign hsum = (cz[CORDIC_STEPS] + (qchc_pkg::Z_W'(1) <<< (qchc_pkg::HROUND - 1)))
                >>> qchc_pkg::HROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      if (hsum > qchc_pkg::Z_W'(qchc_pkg::HMAX)) begin
        head_q <= HW'(qchc_pkg::HMAX);
      end else if (hsum < -qchc_pkg::Z_W'(qchc_pkg::HMAX)) begin
        head_q <= HW'(-qchc_pkg::HMAX);
      end else begin
        head_q <= hsum[HW-1:0];
      end
    end
  end

  // curvature: u = 1 + slope^2, r = isqrt(u)
  logic [OW-1:0]              sa;
  logic [OW-1:0]              pa;
  qchc_pkg::kside_t           k1;
  logic [qchc_pkg::U_W-1:0]   sv [qchc_pkg::SQRT_STEPS+1];
  logic [qchc_pkg::U_W-1:0]   sr [qchc_pkg::SQRT_STEPS+1];
  qchc_pkg::kside_t           ss [qchc_pkg::SQRT_STEPS+1];

  assign sa = r2[qchc_pkg::LANE_S][OW-1] ? -r2[qchc_pkg::LANE_S] : r2[qchc_pkg::LANE_S];
  assign pa = r2[qchc_pkg::LANE_P][OW-1] ? -r2[qchc_pkg::LANE_P] : r2[qchc_pkg::LANE_P];

  always_ff @(posedge clk) begin
    if (en) begin
      k1.u   <= (qchc_pkg::U_W'(1) << (2 * qchc_pkg::X_FRAC_BITS))
                + (qchc_pkg::U_W'(sa) * qchc_pkg::U_W'(sa));
      k1.mag <= pa;
      k1.neg <= r2[qchc_pkg::LANE_P][OW-1];
    end
  end

  assign sv[0] = k1.u;
  assign sr[0] = '0;
  assign ss[0] = k1;

  for (genvar k = 0; k < qchc_pkg::SQRT_STEPS; k++) begin : g_sqrt
    qchc_scell #(.K(k)) u_scell (
      .clk      (clk),
      .en       (en),
      .v_in     (sv[k]),
      .r_in     (sr[k]),
      .side_in  (ss[k]),
      .v_out    (sv[k+1]),
      .r_out    (sr[k+1]),
      .side_out (ss[k+1])
    );
  end

  // den = u * r in two halves, num = |y''| << 3F
  logic [63:0]                  pl;
  logic [63:0]                  ph;
  logic [OW-1:0]                mag2;
  logic                         neg2;
  logic [qchc_pkg::NUM_W-1:0]   drem [qchc_pkg::Q_W+1];
  logic [qchc_pkg::DEN_W-1:0]   dden [qchc_pkg::Q_W+1];
  logic [qchc_pkg::Q_W-1:0]     dq   [qchc_pkg::Q_W+1];
  logic                         dneg [qchc_pkg::Q_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      pl      <= 64'(ss[qchc_pkg::SQRT_STEPS].u[31:0]) * 64'(sr[qchc_pkg::SQRT_STEPS][31:0]);
      ph      <= 64'(ss[qchc_pkg::SQRT_STEPS].u[63:32]) * 64'(sr[qchc_pkg::SQRT_STEPS][31:0]);
      mag2    <= ss[qchc_pkg::SQRT_STEPS].mag;
      neg2    <= ss[qchc_pkg::SQRT_STEPS].neg;
      dden[0] <= (qchc_pkg::DEN_W'(ph) << 32) + qchc_pkg::DEN_W'(pl);
      drem[0] <= qchc_pkg::NUM_W'(mag2) << (3 * qchc_pkg::X_FRAC_BITS);
      dneg[0] <= neg2;
    end
  end

  assign dq[0] = '0;

  for (genvar d = 0; d < qchc_pkg::Q_W; d++) begin : g_div
    qchc_dcell #(.B(qchc_pkg::Q_W - 1 - d)) u_dcell (
      .clk     (clk),
      .en      (en),
      .rem_in  (drem[d]),
      .den_in  (dden[d]),
      .q_in    (dq[d]),
      .neg_in  (dneg[d]),
      .rem_out (drem[d+1]),
      .den_out (dden[d+1]),
      .q_out   (dq[d+1]),
      .neg_out (dneg[d+1])
    );
  end

  // round to nearest, then sign and clamp
  logic [QR_W-1:0] qr;
  logic            neg4;
  logic [OW-1:0]   kval;

  always_ff @(posedge clk) begin
    if (en) begin
      qr   <= QR_W'(dq[qchc_pkg::Q_W])
              + QR_W'((qchc_pkg::DEN_W+1)'({drem[qchc_pkg::Q_W], 1'b0})
                      >= (qchc_pkg::DEN_W+1)'(dden[qchc_pkg::Q_W]));
      neg4 <= dneg[qchc_pkg::Q_W];
      if (neg4) begin
        kval <= (qr > (QR_W'(1) << (OW - 1))) ? {1'b1, {(OW-1){1'b0}}} : -qr[OW-1:0];
      end else begin
        kval <= (qr > QR_W'({1'b0, {(OW-1){1'b1}}})) ? {1'b0, {(OW-1){1'b1}}}
                                                    : qr[OW-1:0];
      end
    end
  end

  // alignment delays
  side_t         sdl [qchc_pkg::CURV_LAT];
  logic [HW-1:0] hdl [HD];

  always_ff @(posedge clk) begin
    if (en) begin
      sdl[0] <= '{p: r2[qchc_pkg::LANE_P], s: r2[qchc_pkg::LANE_S],
                  y: r2[qchc_pkg::LANE_Y], x: x_r2};
      for (int i = 1; i < qchc_pkg::CURV_LAT; i++) begin
        sdl[i] <= sdl[i-1];
      end
      hdl[0] <= head_q;
      for (int i = 1; i < HD; i++) begin
        hdl[i] <= hdl[i-1];
      end
    end
  end

  always_comb begin
    res_in.x_echo       = sdl[qchc_pkg::CURV_LAT-1].x;
    res_in.offset_y     = sdl[qchc_pkg::CURV_LAT-1].y;
    res_in.slope        = sdl[qchc_pkg::CURV_LAT-1].s;
    res_in.second_deriv = sdl[qchc_pkg::CURV_LAT-1].p;
    res_in.heading      = hdl[HD-1];
    res_in.curvature    = kval;
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pipe_vld;
      end
    end else if (pipe_vld) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      res_q <= skid_valid ? skid_q : res_in;
    end else if (pipe_vld) begin
      skid_q <= res_in;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {PAD_W'(0), res_q};

  `QCHC_AST_IMP(a_skid_needs_out, clk, rst, skid_valid, out_valid)
  `QCHC_AST_IMP(a_skid_only_on_stall, clk, rst, $rose(skid_valid),
                $past(out_valid && !m_tready))
  `QCHC_AST_IMP(a_heading_range, clk, rst, out_valid,
                ($signed(res_q.heading) <= $signed(HW'(qchc_pkg::HMAX)))
                && ($signed(res_q.heading) >= $signed(HW'(-qchc_pkg::HMAX))))
  `QCHC_AST_IMP(a_curv_sign, clk, rst, out_valid && res_q.curvature[OW-1],
                res_q.second_deriv[OW-1])

endmodule
